/* src/iir2_pkg.sv */
// iir2_pkg: shared widths, control word types, microcode table and saturation
// helper for the second-order iir step filter.
// No dependencies; used by iir2_mac and second_order_iir_filter_step_top.
package iir2_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 24;

  localparam int COEF_W  = 32;
  localparam int DATA_W  = 32;
  localparam int OUT_W   = 32;
  localparam int PROD_W  = COEF_W + DATA_W;
  localparam int ACC_W   = PROD_W;
  localparam int BLEND_W = 17;
  localparam int BLEND_FRAC = 16;

  // product scaling down to q24.8
  localparam int SHIFT_X = COEF_FRAC_BITS - 8;
  localparam int SHIFT_Y = COEF_FRAC_BITS;

  localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << BLEND_FRAC;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_COEF_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_COEF_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_COEF_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF_1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF_2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_CURRENT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_RATIO     = 3'd7;

  // sequencer program
  localparam int NUM_STEPS = 15;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] STEP_FB   = STEP_W'(3);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  typedef enum logic [2:0] {
    A_Z0, A_Z1, A_Z2, A_P1, A_P2, A_PR, A_W, A_WC
  } a_sel_t;

  typedef enum logic [2:0] {
    B_X, B_X1, B_X2, B_Y1, B_Y2, B_RAW
  } b_sel_t;

  typedef enum logic [1:0] {
    SH_NONE, SH_X, SH_Y
  } shift_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_PRIME, ACT_SAVE_FB, ACT_SAVE_FULL, ACT_FINISH
  } act_t;

  typedef enum logic {
    J_NEXT, J_NO_PRIME
  } jmp_t;

  typedef struct packed {
    logic       rnd_en;
    shift_sel_t sh;
    acc_op_t    acc;
  } mac_ctl_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    mac_ctl_t          mac;
    act_t              act;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam ucode_t UC_NOP = '{
    a_sel:  A_Z0,
    b_sel:  B_X,
    mac:    '{rnd_en: 1'b0, sh: SH_NONE, acc: ACC_HOLD},
    act:    ACT_NONE,
    jmp:    J_NEXT,
    target: '0
  };

  // each product passes the multiplier register, then the rounding register, then the accumulator, in successive steps
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] s);
    ucode_t u;
    u = UC_NOP;
    case (s)
      STEP_W'(0): begin
        u.a_sel = A_PR; u.b_sel = B_X;
        u.jmp = J_NO_PRIME; u.target = STEP_FB;
      end
      STEP_W'(1): begin
        u.mac.rnd_en = 1'b1; u.mac.sh = SH_X;
      end
      STEP_W'(2): begin
        u.act = ACT_PRIME;
      end
      STEP_W'(3): begin
        u.a_sel = A_P1; u.b_sel = B_Y1;
      end
      STEP_W'(4): begin
        u.a_sel = A_P2; u.b_sel = B_Y2;
        u.mac.rnd_en = 1'b1; u.mac.sh = SH_Y;
      end
      STEP_W'(5): begin
        u.a_sel = A_Z0; u.b_sel = B_X;
        u.mac.rnd_en = 1'b1; u.mac.sh = SH_Y; u.mac.acc = ACC_LOAD;
      end
      STEP_W'(6): begin
        u.a_sel = A_Z1; u.b_sel = B_X1;
        u.mac.rnd_en = 1'b1; u.mac.sh = SH_X; u.mac.acc = ACC_ADD;
      end
      STEP_W'(7): begin
        u.a_sel = A_Z2; u.b_sel = B_X2;
        u.mac.rnd_en = 1'b1; u.mac.sh = SH_X; u.mac.acc = ACC_ADD;
        u.act = ACT_SAVE_FB;
      end
      STEP_W'(8): begin
        u.a_sel = A_W; u.b_sel = B_Y1;
        u.mac.rnd_en = 1'b1; u.mac.sh = SH_X; u.mac.acc = ACC_ADD;
      end
      STEP_W'(9): begin
        u.mac.rnd_en = 1'b1; u.mac.sh = SH_NONE; u.mac.acc = ACC_ADD;
      end
      STEP_W'(10): begin
        u.mac.acc = ACC_LOAD; u.act = ACT_SAVE_FULL;
      end
      STEP_W'(11): begin
        u.a_sel = A_WC; u.b_sel = B_RAW;
      end
      STEP_W'(12): begin
        u.mac.rnd_en = 1'b1; u.mac.sh = SH_NONE;
      end
      STEP_W'(13): begin
        u.mac.acc = ACC_ADD;
      end
      STEP_W'(14): begin
        u.act = ACT_FINISH;
      end
      default: begin
        u = UC_NOP;
      end
    endcase
    return u;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo = {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    if (v > hi) begin
      return hi[OUT_W-1:0];
    end else if (v < lo) begin
      return lo[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

/* src/iir2_mac.sv */
// iir2_mac: shared multiply, round and accumulate datapath.
// Depends on iir2_pkg; driven one control word per cycle by the top level.
module iir2_mac
  import iir2_pkg::*;
(
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [ACC_W-1:0]  rnd,
  output logic signed [ACC_W-1:0]  acc
);

  localparam logic signed [PROD_W-1:0] HALF_X = PROD_W'(1) << (SHIFT_X - 1);
  localparam logic signed [PROD_W-1:0] HALF_Y = PROD_W'(1) << (SHIFT_Y - 1);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  rnd_next;
  logic signed [ACC_W-1:0]  acc_next;

  // round half up, then floor
  always_comb begin
    case (ctl.sh)
      SH_X:    rnd_next = (prod + HALF_X) >>> SHIFT_X;
      SH_Y:    rnd_next = (prod + HALF_Y) >>> SHIFT_Y;
      default: rnd_next = prod;
    endcase
  end

  always_comb begin
    case (ctl.acc)
      ACC_LOAD: acc_next = rnd;
      ACC_ADD:  acc_next = acc + rnd;
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctl.rnd_en) begin
      rnd <= rnd_next;
    end
    acc <= acc_next;
  end

endmodule

/* src/second_order_iir_filter_step_top.sv */
// second_order_iir_filter_step_top: direct form 1 biquad step with priming and blend,
// run by a microcode table over one shared multiply-accumulate unit.
// Depends on iir2_pkg and iir2_mac.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+-------------------------------
//   in        | input     | in_valid / in_stall  | sample, prime
//   out       | output    | out_valid / out_stall| filtered
//   cfg       | input     | cfg_write            | cfg_index, cfg_data
//
// a word runs the microcode steps from accept to result, and skips the prime steps
// when prime is clear; each product passes the single multiplier, rounding and accumulator.
// a new word is taken the cycle after the last step, while a result may still
// sit in the output register; the last step waits while that register is full
// and stalled. rst is synchronous and resets the configuration, history and control registers.
module second_order_iir_filter_step_top
  import iir2_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           prime,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [OUT_W-1:0]        filtered,
  input  logic                           cfg_write,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_W-1:0]              cfg_data
);

  localparam logic signed [ACC_W-1:0] BLEND_HALF = ACC_W'(1) << (BLEND_FRAC - 1);

  logic signed [COEF_W-1:0]       zero_coef_0;
  logic signed [COEF_W-1:0]       zero_coef_1;
  logic signed [COEF_W-1:0]       zero_coef_2;
  logic signed [COEF_W-1:0]       pole_coef_1;
  logic signed [COEF_W-1:0]       pole_coef_2;
  logic [BLEND_W-1:0]             blend_weight;
  logic                           include_current;
  logic signed [COEF_W-1:0]       prime_ratio;

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] x1;
  logic signed [SAMPLE_WIDTH-1:0] x2;
  logic signed [OUT_W-1:0]        y1;
  logic signed [OUT_W-1:0]        y2;
  logic                           prime_q;
  logic signed [OUT_W-1:0]        fb_sat;
  logic signed [OUT_W-1:0]        full_sat;
  logic signed [OUT_W-1:0]        raw;

  logic                           running;
  logic [STEP_W-1:0]              step;

  ucode_t                         uc;
  ucode_t                         ctl;
  logic                           hold;
  logic [BLEND_W-1:0]             w_eff;
  logic [BLEND_W-1:0]             w_comp;
  logic signed [COEF_W-1:0]       op_a;
  logic signed [DATA_W-1:0]       op_b;
  logic signed [ACC_W-1:0]        rnd;
  logic signed [ACC_W-1:0]        acc;
  logic signed [OUT_W-1:0]        acc_sat;
  logic signed [OUT_W-1:0]        blend_sat;

  assign uc  = ucode_rom(step);
  assign ctl = running ? uc : UC_NOP;

  assign in_stall = running;
  // last step waits for room in the output register
  assign hold = (ctl.act == ACT_FINISH) && out_valid && out_stall;

  assign w_eff  = (blend_weight > BLEND_ONE) ? BLEND_ONE : blend_weight;
  assign w_comp = BLEND_ONE - w_eff;

  always_comb begin
    case (ctl.a_sel)
      A_Z0:    op_a = zero_coef_0;
      A_Z1:    op_a = zero_coef_1;
      A_Z2:    op_a = zero_coef_2;
      A_P1:    op_a = pole_coef_1;
      A_P2:    op_a = pole_coef_2;
      A_PR:    op_a = prime_ratio;
      A_W:     op_a = COEF_W'(w_eff);
      A_WC:    op_a = COEF_W'(w_comp);
      default: op_a = '0;
    endcase
  end

  always_comb begin
    case (ctl.b_sel)
      B_X:     op_b = DATA_W'(x);
      B_X1:    op_b = DATA_W'(x1);
      B_X2:    op_b = DATA_W'(x2);
      B_Y1:    op_b = DATA_W'(y1);
      B_Y2:    op_b = DATA_W'(y2);
      B_RAW:   op_b = DATA_W'(raw);
      default: op_b = '0;
    endcase
  end

  iir2_mac u_mac (
    .clk (clk),
    .ctl (ctl.mac),
    .a   (op_a),
    .b   (op_b),
    .rnd (rnd),
    .acc (acc)
  );

  assign acc_sat   = sat_out(acc);
  assign blend_sat = sat_out((acc + BLEND_HALF) >>> BLEND_FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_coef_0     <= '0;
      zero_coef_1     <= '0;
      zero_coef_2     <= '0;
      pole_coef_1     <= '0;
      pole_coef_2     <= '0;
      blend_weight    <= '0;
      include_current <= 1'b1;
      prime_ratio     <= '0;
      x1              <= '0;
      x2              <= '0;
      y1              <= '0;
      y2              <= '0;
      running         <= 1'b0;
      step            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ZERO_COEF_0:     zero_coef_0     <= cfg_data;
          REG_ZERO_COEF_1:     zero_coef_1     <= cfg_data;
          REG_ZERO_COEF_2:     zero_coef_2     <= cfg_data;
          REG_POLE_COEF_1:     pole_coef_1     <= cfg_data;
          REG_POLE_COEF_2:     pole_coef_2     <= cfg_data;
          REG_BLEND_WEIGHT:    blend_weight    <= cfg_data[BLEND_W-1:0];
          REG_INCLUDE_CURRENT: include_current <= cfg_data[0];
          REG_PRIME_RATIO:     prime_ratio     <= cfg_data;
          default: ;
        endcase
      end

      if (ctl.act == ACT_FINISH && !hold) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (!running) begin
        if (in_valid) begin
          running <= 1'b1;
          step    <= '0;
          x       <= sample;
          prime_q <= prime;
        end
      end else if (!hold) begin
        if (ctl.act == ACT_FINISH) begin
          running <= 1'b0;
        end else if (ctl.jmp == J_NO_PRIME && !prime_q) begin
          step <= ctl.target;
        end else begin
          step <= step + STEP_W'(1);
        end
      end

      case (ctl.act)
        ACT_PRIME: begin
          x1 <= x;
          x2 <= x;
          y1 <= sat_out(rnd);
          y2 <= sat_out(rnd);
        end
        ACT_SAVE_FB: begin
          fb_sat <= acc_sat;
        end
        ACT_SAVE_FULL: begin
          full_sat <= acc_sat;
          raw      <= include_current ? acc_sat : fb_sat;
        end
        ACT_FINISH: begin
          if (!hold) begin
            filtered  <= blend_sat;
            y2        <= y1;
            y1        <= full_sat;
            x2        <= x1;
            x1        <= x;
          end
        end
        default: ;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (running && step == '0))
    else $error("accepted word did not start the program at step zero");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    running |-> (step <= LAST_STEP))
    else $error("step counter ran past the program");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(running && uc.act == ACT_FINISH))
    else $error("result posted outside the finish step");

  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    (running && uc.act == ACT_FINISH && out_valid && out_stall) |=>
      (running && uc.act == ACT_FINISH))
    else $error("finish step left while output register was blocked");

endmodule

/* bench/second_order_iir_filter_step_top_tb.sv */
// second_order_iir_filter_step_top_tb: checks the biquad step filter word by word against
// a fixed-point predictor of the same arithmetic, over directed and random register settings.
// Depends on iir2_pkg and second_order_iir_filter_step_top.
module second_order_iir_filter_step_top_tb;
  import iir2_pkg::*;

  localparam int XSH = COEF_FRAC_BITS - 8;
  localparam int YSH = COEF_FRAC_BITS;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 115;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] x;
    logic                           p;
  } word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample = '0;
  logic                           prime = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [OUT_W-1:0]        filtered;
  logic                           cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [COEF_W-1:0]              cfg_data = '0;

  // pacing controls; the flags are changed by the sequence, the counters by the driver and monitor, at clock edges
  logic src_busy = 1'b0;
  logic dst_busy = 1'b0;
  logic hold_req = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;

  word_t             pending_words[$];
  logic signed [31:0] filt_expect[$];
  int unsigned       mismatches = 0;
  logic [31:0]       cfg_img[8];

  // predictor copy of registers and history
  longint z0_c = 0, z1_c = 0, z2_c = 0, p1_c = 0, p2_c = 0, ratio_c = 0;
  longint wt_c = 0;
  logic   incl_c = 1'b1;
  longint x_back1 = 0, x_back2 = 0, y_back1 = 0, y_back2 = 0;

  second_order_iir_filter_step_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .prime(prime),
    .out_valid(out_valid), .out_stall(out_stall), .filtered(filtered),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // add one half then floor, so ties go toward plus infinity
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [31:0] filter_word(input logic signed [SAMPLE_WIDTH-1:0] x_in,
                                                     input logic prm);
    longint x, y_pr, fb, full, raw, w, mix;
    x = x_in;
    if (prm) begin
      y_pr = clip32(rnd_shift(ratio_c * x, XSH));
      x_back1 = x;
      x_back2 = x;
      y_back1 = y_pr;
      y_back2 = y_pr;
    end
    fb = rnd_shift(p1_c * y_back1, YSH) + rnd_shift(p2_c * y_back2, YSH);
    full = fb + rnd_shift(z0_c * x, XSH) + rnd_shift(z1_c * x_back1, XSH)
           + rnd_shift(z2_c * x_back2, XSH);
    fb = clip32(fb);
    full = clip32(full);
    raw = incl_c ? full : fb;
    w = (wt_c > 65536) ? 65536 : wt_c;
    mix = clip32((w * y_back1 + (65536 - w) * raw + 32768) >>> 16);
    // feedback history keeps the full sum in both modes
    y_back2 = y_back1;
    y_back1 = full;
    x_back2 = x_back1;
    x_back1 = x;
    return mix[31:0];
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    case (idx)
      REG_ZERO_COEF_0:     z0_c = $signed(d);
      REG_ZERO_COEF_1:     z1_c = $signed(d);
      REG_ZERO_COEF_2:     z2_c = $signed(d);
      REG_POLE_COEF_1:     p1_c = $signed(d);
      REG_POLE_COEF_2:     p2_c = $signed(d);
      REG_BLEND_WEIGHT:    wt_c = d[BLEND_W-1:0];
      REG_INCLUDE_CURRENT: incl_c = d[0];
      REG_PRIME_RATIO:     ratio_c = $signed(d);
      default: ;
    endcase
  endfunction

  // writes every register from cfg_img, one per cycle; called while idle
  task automatic program_regs();
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < 8; i++) begin
      idx = CFG_IDX_W'(i);
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data <= cfg_img[i];
      apply_reg(idx, cfg_img[i]);
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_word(input logic signed [SAMPLE_WIDTH-1:0] x, input logic p);
    word_t w;
    w.x = x;
    w.p = p;
    pending_words.push_back(w);
  endtask

  // sequence waits until every word is out and every result is back
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || filt_expect.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coef(input bit pole);
    int v;
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0;
      default: begin
        // mostly within plus or minus one, feedback within a half
        v = $urandom_range(0, 33554432) - 16777216;
        return pole ? (v >>> 1) : v;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_blend();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd65536;
      2, 3: return $urandom_range(0, 65536);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2, 3: return SAMPLE_WIDTH'($urandom_range(0, 512) - 256);
      default: return SAMPLE_WIDTH'($urandom());
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin : drive_in
    int gap_n;
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      gap_n = gap_left;
      if (in_valid && !in_stall) begin
        filt_expect.push_back(filter_word(sample, prime));
        gap_n = src_busy ? $urandom_range(0, 4) : 0;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_n > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_n - 1;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          sample <= w.x;
          prime <= w.p;
          gap_left <= 0;
        end else begin
          in_valid <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : watch_out
    int n;
    logic signed [31:0] want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      n = stall_left;
      if (out_valid && !out_stall) begin
        if (filt_expect.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0d", $time, filtered);
          mismatches++;
        end else begin
          want = filt_expect.pop_front();
          if (filtered !== want) begin
            $display("%0t: filtered wrong, expected %0d, got %0d", $time, want, filtered);
            mismatches++;
          end
        end
        n = dst_busy ? $urandom_range(0, 4) : 0;
      end
      if (hold_req) n = LONG_HOLD;
      if (n > 0) begin
        out_stall <= 1'b1;
        stall_left <= n - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: all coefficients zero
    queue_word(24'sh7FFFFF, 1'b0);
    queue_word(24'sh800000, 1'b1);
    queue_word(24'sh000123, 1'b0);
    drain();

    // extreme coefficients, saturation everywhere
    cfg_img = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h0, 32'h1, 32'h7FFF_FFFF};
    program_regs();
    queue_word(24'sh7FFFFF, 1'b1);
    queue_word(24'sh800000, 1'b0);
    queue_word(24'sh000000, 1'b0);
    queue_word(24'sh800000, 1'b1);
    queue_word(24'sh000001, 1'b0);
    queue_word(-24'sd1, 1'b0);
    drain();

    // half-lsb ties, blend above one, feedback-only output
    cfg_img = '{32'h0000_8000, 32'h0000_8000, 32'hFFFF_8000, 32'h0080_0000,
                32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000};
    program_regs();
    queue_word(24'sd1, 1'b0);
    queue_word(-24'sd1, 1'b0);
    queue_word(24'sd1, 1'b1);
    queue_word(24'sd3, 1'b0);
    queue_word(-24'sd3, 1'b0);
    drain();

    // unit blend, then a mid blend with a stable low-pass
    cfg_img = '{32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h00C0_0000,
                32'hFFC0_0000, 32'd65536, 32'h1, 32'h0080_0000};
    program_regs();
    queue_word(24'sd1000, 1'b1);
    queue_word(24'sh7FFFFF, 1'b0);
    queue_word(24'sh800000, 1'b0);
    drain();
    cfg_img[REG_BLEND_WEIGHT] = 32'h8000;
    program_regs();
    queue_word(24'sd5, 1'b0);
    queue_word(-24'sd7, 1'b1);
    queue_word(24'sd40000, 1'b0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_img[REG_ZERO_COEF_0] = pick_coef(1'b0);
      cfg_img[REG_ZERO_COEF_1] = pick_coef(1'b0);
      cfg_img[REG_ZERO_COEF_2] = pick_coef(1'b0);
      cfg_img[REG_POLE_COEF_1] = pick_coef(1'b1);
      cfg_img[REG_POLE_COEF_2] = pick_coef(1'b1);
      cfg_img[REG_BLEND_WEIGHT] = pick_blend();
      cfg_img[REG_INCLUDE_CURRENT] = $urandom();
      cfg_img[REG_PRIME_RATIO] = pick_coef(1'b0);
      program_regs();
      @(posedge clk);
      src_busy <= (ph % 3 != 0) && (ph != 4);
      dst_busy <= (ph % 2 != 0);
      @(negedge clk);
      for (int k = 0; k < PHASE_WORDS; k++)
        queue_word(pick_sample(), $urandom_range(0, 11) == 0);
      if (ph == 4) begin
        // receiver holds off while the sender keeps offering, so input backs up
        repeat (30) @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && filt_expect.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
